// File: rtl/core/sha1_pkg.sv
`timescale 1ns / 1ps

package sha1_pkg;

  localparam int unsigned NumWords = 5;
  localparam int unsigned SchedDepth = 16;

  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [6:0] RoundExpand = 7'd16;
  localparam logic [6:0] RoundStage1 = 7'd20;
  localparam logic [6:0] RoundStage2 = 7'd40;
  localparam logic [6:0] RoundStage3 = 7'd60;

  localparam logic [5:0] PadLenPos = 6'd56;
  localparam logic [5:0] BlkLastPos = 6'd63;
  localparam logic [1:0] WordLastByte = 2'd3;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [2:0] WordIdxLast = 3'd4;

  typedef logic [NumWords-1:0][31:0] word5_t;

  localparam word5_t ChainInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_data_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } out_data_t;

  typedef struct packed {
    logic push;
    logic roll;
    logic expand;
  } sched_ctl_t;

  function automatic logic [31:0] round_k(input logic [1:0] stage);
    logic [31:0] k;
    case (stage)
      2'd0: k = 32'h5A827999;
      2'd1: k = 32'h6ED9EBA1;
      2'd2: k = 32'h8F1BBCDC;
      default: k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/core/sha1_hash_core_unit.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                    | Word
// input    | in        | in_valid_i / in_ready_o      | in_data_t  (byte, has_byte, last)
// output   | out       | out_valid_o / out_ready_i    | out_data_t (digest word, index, final)
//
// A byte without last is stored and leaves the unit ready; a byte that completes
// a 64-byte block runs the 80 rounds, one round a cycle through the round unit,
// then the add. A last byte is followed by 9 to 72 padding bytes, with the rounds
// and add run for each block padded, then five digest words, one per cycle while
// out_ready_i is high. in_ready_o is low from a block-completing byte until its
// block is added, and from a last byte until the fifth digest word is taken.
// Reset loads the initial chaining words and clears the byte count.

module sha1_hash_core_unit
  import sha1_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_data_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_data_t out_data_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [60:0] cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [23:0] word_q, word_d;
  logic [6:0]  rnd_q, rnd_d;
  word5_t      vars_q, vars_d;
  word5_t      chain_q, chain_d;
  logic        fin_q, fin_d;
  logic        pad80_q, pad80_d;
  logic        lenph_q, lenph_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        ovalid_q, ovalid_d;

  logic        in_acc;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        len_sel;
  logic        blk_full;
  logic [5:0]  pos;
  sched_ctl_t  sched_ctl;
  logic [31:0] wt;
  word5_t      vars_nx;

  sha1_sched u_sched (
    .clk_i       (clk_i),
    .ctl_i       (sched_ctl),
    .load_word_i ({word_q, wr_byte}),
    .wt_o        (wt)
  );

  sha1_round u_round (
    .vars_i (vars_q),
    .rnd_i  (rnd_q),
    .wt_i   (wt),
    .vars_o (vars_nx)
  );

  assign pos = cnt_q[5:0];
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc = in_valid_i && in_ready_o;
  assign len_sel = (state_q == S_PAD) && !pad80_q && (lenph_q || (pos == PadLenPos));

  always_comb begin
    wr_en = 1'b0;
    wr_byte = in_data_i.data_byte;
    if (state_q == S_IDLE) begin
      wr_en = in_acc && in_data_i.has_byte;
    end else if (state_q == S_PAD) begin
      wr_en = 1'b1;
      if (pad80_q) begin
        wr_byte = PadByte;
      end else if (len_sel) begin
        wr_byte = len_q[63:56];
      end else begin
        wr_byte = 8'h00;
      end
    end
  end

  assign blk_full = wr_en && (pos == BlkLastPos);

  always_comb begin
    sched_ctl.push = wr_en && (pos[1:0] == WordLastByte);
    sched_ctl.roll = (state_q == S_COMP);
    sched_ctl.expand = (rnd_q >= RoundExpand);
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    len_d = len_q;
    word_d = word_q;
    rnd_d = rnd_q;
    vars_d = vars_q;
    chain_d = chain_q;
    fin_d = fin_q;
    pad80_d = pad80_q;
    lenph_d = lenph_q;
    oidx_d = oidx_q;
    ovalid_d = ovalid_q;

    if (wr_en) begin
      cnt_d = cnt_q + 61'd1;
      word_d = {word_q[15:0], wr_byte};
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.last) begin
          fin_d = 1'b1;
          pad80_d = 1'b1;
          len_d = {cnt_d, 3'b000};
          state_d = S_PAD;
        end
      end
      S_PAD: begin
        pad80_d = 1'b0;
        if (len_sel) begin
          len_d = {len_q[55:0], 8'h00};
          lenph_d = 1'b1;
        end
      end
      S_COMP: begin
        vars_d = vars_nx;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == RoundLast) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < NumWords; i++) begin
          chain_d[i] = chain_q[i] + vars_q[i];
        end
        if (lenph_q) begin
          state_d = S_OUT;
          ovalid_d = 1'b1;
          oidx_d = 3'd0;
        end else if (fin_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (oidx_q == WordIdxLast) begin
            ovalid_d = 1'b0;
            chain_d = ChainInit;
            cnt_d = '0;
            fin_d = 1'b0;
            pad80_d = 1'b0;
            lenph_d = 1'b0;
            state_d = S_IDLE;
          end else begin
            oidx_d = oidx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a full block overrides the byte path's next state
    if (blk_full) begin
      state_d = S_COMP;
      rnd_d = '0;
      vars_d = chain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      chain_q <= ChainInit;
      vars_q <= '0;
      rnd_q <= '0;
      fin_q <= 1'b0;
      pad80_q <= 1'b0;
      lenph_q <= 1'b0;
      oidx_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      chain_q <= chain_d;
      vars_q <= vars_d;
      rnd_q <= rnd_d;
      fin_q <= fin_d;
      pad80_q <= pad80_d;
      lenph_q <= lenph_d;
      oidx_q <= oidx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    word_q <= word_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o.digest_word = chain_q[oidx_q];
  assign out_data_o.word_index = oidx_q;
  assign out_data_o.final_word = (oidx_q == WordIdxLast);

endmodule

// File: rtl/core/sha1_sched.sv
`timescale 1ns / 1ps

module sha1_sched
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  sched_ctl_t  ctl_i,
  input  logic [31:0] load_word_i,
  output logic [31:0] wt_o
);

  logic [31:0] line_q [SchedDepth];
  logic [31:0] mix;

  // taps hold W(t-16), W(t-14), W(t-8), W(t-3)
  assign mix = line_q[0] ^ line_q[2] ^ line_q[8] ^ line_q[13];
  assign wt_o = ctl_i.expand ? {mix[30:0], mix[31]} : line_q[0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.push || ctl_i.roll) begin
      for (int i = 0; i < SchedDepth - 1; i++) begin
        line_q[i] <= line_q[i+1];
      end
      line_q[SchedDepth-1] <= ctl_i.push ? load_word_i : wt_o;
    end
  end

endmodule

// File: rtl/core/sha1_round.sv
`timescale 1ns / 1ps

module sha1_round
  import sha1_pkg::*;
(
  input  word5_t      vars_i,
  input  logic [6:0]  rnd_i,
  input  logic [31:0] wt_i,
  output word5_t      vars_o
);

  logic [1:0]  stage;
  logic [31:0] a, b, c, d, e, f, tmp;

  assign a = vars_i[0];
  assign b = vars_i[1];
  assign c = vars_i[2];
  assign d = vars_i[3];
  assign e = vars_i[4];

  always_comb begin
    if (rnd_i < RoundStage1) begin
      stage = 2'd0;
    end else if (rnd_i < RoundStage2) begin
      stage = 2'd1;
    end else if (rnd_i < RoundStage3) begin
      stage = 2'd2;
    end else begin
      stage = 2'd3;
    end
  end

  always_comb begin
    case (stage)
      2'd0: f = (b & c) | (~b & d);
      2'd2: f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + round_k(stage) + wt_i;

  assign vars_o[0] = tmp;
  assign vars_o[1] = a;
  assign vars_o[2] = {b[1:0], b[31:2]};
  assign vars_o[3] = c;
  assign vars_o[4] = d;

endmodule

// File: rtl/core/sha1_checker.sv
`timescale 1ns / 1ps

module sha1_checker
  import sha1_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_data_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_data_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("digest word changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while digest pending");

  a_final_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.final_word == (out_data_o.word_index == WordIdxLast)))
    else $error("final flag does not match word index");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.final_word |=>
      out_valid_o && (out_data_o.word_index == $past(out_data_o.word_index) + 3'd1))
    else $error("digest words out of order");

  a_done_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.final_word |=> in_ready_o && !out_valid_o)
    else $error("not ready after last digest word");

endmodule

bind sha1_hash_core_unit sha1_checker u_sha1_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
